// File: sv/ipv4p_pkg.sv
// ----------------------------------------------------------------------------
// ipv4p_pkg
// shared types and constants of the ipv4 dotted-text parser
// ----------------------------------------------------------------------------
package ipv4p_pkg;

	localparam int unsigned CHAR_W = 8;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned IN_TDATA_W = 8;
	localparam int unsigned OUT_TDATA_W = 40;

	localparam logic [ADDR_W-1:0] LIM_TWO_PARTS = 32'h00ff_ffff;
	localparam logic [ADDR_W-1:0] LIM_THREE_PARTS = 32'h0000_ffff;
	localparam logic [ADDR_W-1:0] LIM_FOUR_PARTS = 32'h0000_00ff;

	localparam logic [CHAR_W-1:0] CH_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_DOT = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CH_X_LO = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UP = 8'h58;
	localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
	localparam logic [CHAR_W-1:0] CH_F_LO = 8'h66;
	localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;
	localparam logic [CHAR_W-1:0] CH_F_UP = 8'h46;

	typedef enum logic [1:0] {
		PH_DONE,
		PH_START,
		PH_ZERO,
		PH_DIGITS
	} phase_t;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef struct packed {
		logic              emit;
		logic              ok;
		logic [ADDR_W-1:0] address;
	} res_t;

	function automatic logic is_dec(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_ws(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

// File: sv/ipv4p_core.sv
// ----------------------------------------------------------------------------
// ipv4p_core
// parser state and combinational character step
// ----------------------------------------------------------------------------
module ipv4p_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [ipv4p_pkg::CHAR_W-1:0]  ch,
	input  logic                          new_string,
	output ipv4p_pkg::res_t               res
);
	import ipv4p_pkg::*;

	phase_t              phase_q;
	radix_t              radix_q;
	logic [ADDR_W-1:0]   acc_q;
	logic [1:0]          pc_q;
	logic [ADDR_W-1:0]   saved_q [3];

	phase_t              eph;
	radix_t              erad;
	radix_t              drad;
	logic [ADDR_W-1:0]   eacc;
	logic [1:0]          epc;

	logic                c_dec;
	logic                c_hex;
	logic                c_dot;
	logic                c_end;
	logic                c_x;
	logic [3:0]          dval;
	logic [ADDR_W-1:0]   acc_step;
	logic                fin_ok;
	logic [ADDR_W-1:0]   fin_val;

	phase_t              phase_d;
	radix_t              radix_d;
	logic [ADDR_W-1:0]   acc_d;
	logic [1:0]          pc_d;
	logic                save_we;

	// character classes and arithmetic shared by the next-state and result blocks
	always_comb begin
		eph = new_string ? PH_START : phase_q;
		erad = new_string ? RADIX_DEC : radix_q;
		eacc = new_string ? '0 : acc_q;
		epc = new_string ? 2'd0 : pc_q;
		drad = (eph == PH_ZERO) ? RADIX_OCT : erad;

		c_dec = is_dec(ch);
		c_hex = (drad == RADIX_HEX) &&
			(((ch >= CH_A_LO) && (ch <= CH_F_LO)) || ((ch >= CH_A_UP) && (ch <= CH_F_UP)));
		c_dot = (ch == CH_DOT);
		c_end = (ch == CH_NUL) || is_ws(ch);
		c_x = (ch == CH_X_LO) || (ch == CH_X_UP);
		dval = c_dec ? ch[3:0] : ch[3:0] + 4'd9;

		case (drad)
			RADIX_HEX: acc_step = (eacc << 4) + {{(ADDR_W-4){1'b0}}, dval};
			RADIX_OCT: acc_step = (eacc << 3) + {{(ADDR_W-4){1'b0}}, dval};
			default:   acc_step = (eacc << 3) + (eacc << 1) + {{(ADDR_W-4){1'b0}}, dval};
		endcase

		fin_ok = 1'b1;
		fin_val = eacc;
		case (epc)
			2'd1: begin
				fin_ok = (eacc <= LIM_TWO_PARTS);
				fin_val = eacc | (saved_q[0] << 24);
			end
			2'd2: begin
				fin_ok = (eacc <= LIM_THREE_PARTS);
				fin_val = eacc | (saved_q[0] << 24) | (saved_q[1] << 16);
			end
			2'd3: begin
				fin_ok = (eacc <= LIM_FOUR_PARTS);
				fin_val = eacc | (saved_q[0] << 24) | (saved_q[1] << 16) | (saved_q[2] << 8);
			end
			default: begin
				fin_ok = 1'b1;
				fin_val = eacc;
			end
		endcase
	end

	// next state
	always_comb begin
		phase_d = eph;
		radix_d = erad;
		acc_d = eacc;
		pc_d = epc;
		save_we = 1'b0;
		unique case (eph)
			PH_START: begin
				if (!c_dec) begin
					phase_d = PH_DONE;
				end else if (ch == CH_ZERO) begin
					acc_d = '0;
					phase_d = PH_ZERO;
				end else begin
					radix_d = RADIX_DEC;
					acc_d = {{(ADDR_W-4){1'b0}}, dval};
					phase_d = PH_DIGITS;
				end
			end
			PH_ZERO, PH_DIGITS: begin
				phase_d = PH_DIGITS;
				radix_d = drad;
				if ((eph == PH_ZERO) && c_x) begin
					radix_d = RADIX_HEX;
				end else if (c_dec || c_hex) begin
					acc_d = acc_step;
				end else if (c_dot && (epc != 2'd3)) begin
					save_we = 1'b1;
					pc_d = epc + 2'd1;
					phase_d = PH_START;
				end else begin
					phase_d = PH_DONE;
				end
			end
			default: begin
				phase_d = eph;
			end
		endcase
	end

	// result of this character
	always_comb begin
		res = '0;
		unique case (eph)
			PH_START: begin
				res.emit = !c_dec;
			end
			PH_ZERO, PH_DIGITS: begin
				if (!((eph == PH_ZERO) && c_x) && !c_dec && !c_hex &&
					!(c_dot && (epc != 2'd3))) begin
					res.emit = 1'b1;
					res.ok = c_end && fin_ok;
					res.address = (c_end && fin_ok) ? fin_val : '0;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			radix_q <= RADIX_DEC;
			acc_q <= '0;
			pc_q <= 2'd0;
		end else if (step_en) begin
			phase_q <= phase_d;
			radix_q <= radix_d;
			acc_q <= acc_d;
			pc_q <= pc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && save_we) begin
			saved_q[epc] <= eacc;
		end
	end

`ifndef SYNTHESIS
	a_idle_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && !new_string) |-> !res.emit)
		else $error("result while waiting for a new string");
	a_err_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(res.emit && !res.ok) |-> (res.address == '0))
		else $error("error result carries nonzero address");
	a_emit_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.emit) |=> (phase_q == PH_DONE))
		else $error("parser not done after result");
`endif

endmodule

// File: sv/ipv4_dotted_text_parser.sv
// ----------------------------------------------------------------------------
// ipv4_dotted_text_parser
// streaming inet_aton style parser of dotted ipv4 address text
// ----------------------------------------------------------------------------
// input channel s_axis: one character per transaction in tdata[7:0], tuser
// high on the first character of a string. output channel m_axis: one
// transaction per string, tdata[0] = ok, tdata[32:1] = address (zero on error).
// a string yields its result on the character that ends it (nul or
// whitespace) or on the first error; later characters are dropped until the
// next tuser mark.
// a character enters the input register, is parsed there against the parser
// state and its result lands in the output register.
// throughput: one character per cycle while no result waits on a stalled
// output, with the accumulator update (shift-and-add by the radix) done
// combinationally in the parser core.
// reset clears both register stages and puts the parser in its done state,
// so characters are ignored until one arrives with tuser set.
// when m_axis_tready is low with a result pending, characters that produce
// no result still advance; a character that would produce a result waits in
// the input register and s_axis_tready drops until the output is taken.
// ----------------------------------------------------------------------------
module ipv4_dotted_text_parser (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [ipv4p_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // ch[7:0]
	input  logic                                 s_axis_tuser,  // new_string
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [ipv4p_pkg::OUT_TDATA_W-1:0]    m_axis_tdata   // ok, address[31:0], zero pad
);
	import ipv4p_pkg::*;

	logic                v_s1;
	logic [CHAR_W-1:0]   ch_s1;
	logic                ns_s1;
	logic                v_s2;
	logic                ok_s2;
	logic [ADDR_W-1:0]   addr_s2;
	logic                adv;
	res_t                res;

	assign adv = v_s1 && (!res.emit || !v_s2 || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv;

	ipv4p_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (adv),
		.ch         (ch_s1),
		.new_string (ns_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			ch_s1 <= s_axis_tdata[CHAR_W-1:0];
			ns_s1 <= s_axis_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv && res.emit) begin
			v_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.emit) begin
			ok_s2 <= res.ok;
			addr_s2 <= res.address;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata = {{(OUT_TDATA_W-ADDR_W-1){1'b0}}, addr_s2, ok_s2};

`ifndef SYNTHESIS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv) |=> (v_s1 && $stable(ch_s1) && $stable(ns_s1)))
		else $error("stalled character lost from input register");
	a_load_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.emit) |=> v_s2)
		else $error("result not loaded into output register");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !m_axis_tready) |-> !(adv && res.emit))
		else $error("pending result overwritten");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !ok_s2) |-> (addr_s2 == '0))
		else $error("error result with nonzero address");
`endif

endmodule

// File: verif/ipv4_result_checker.sv
// ----------------------------------------------------------------------------
// ipv4_result_checker
// watches both channels of the ipv4 dotted-text parser, predicts from the accepted
// characters the address result of every string that ends or fails and compares each
// output transaction with the oldest predicted result
// ----------------------------------------------------------------------------
module ipv4_result_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	input  logic                              s_axis_tready,
	input  logic [ipv4p_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // ch[7:0]
	input  logic                              s_axis_tuser,  // new_string
	input  logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	input  logic [ipv4p_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // ok, address[31:0], zero pad
	output int unsigned                       outstanding,
	output int unsigned                       mismatch_count
);
	import ipv4p_pkg::*;

	typedef struct packed {
		logic              ok;
		logic [ADDR_W-1:0] address;
	} addr_result_t;

	phase_t            parse_phase;
	radix_t            parse_radix;
	logic [ADDR_W-1:0] acc;
	logic [1:0]        parts_closed;
	logic [ADDR_W-1:0] part_store [3];
	addr_result_t      expected_addrs [$];

	logic              produced;
	addr_result_t      predicted;
	addr_result_t      want;
	addr_result_t      got;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic parse_char(
		input  logic [CHAR_W-1:0] c,
		input  logic              restart,
		output logic              done,
		output addr_result_t      res
	);
		logic              dec_digit;
		logic              blank;
		logic              take_digit;
		logic [ADDR_W-1:0] weight;
		dec_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		blank = (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
		take_digit = 1'b0;
		done = 1'b0;
		res = '0;
		if (restart) begin
			parse_phase = PH_START;
			parts_closed = 2'd0;
			parse_radix = RADIX_DEC;
			acc = '0;
		end
		case (parse_phase)
			PH_START: begin
				if (!dec_digit) begin
					done = 1'b1;
				end else begin
					acc = '0;
					if (c == CH_ZERO) begin
						parse_phase = PH_ZERO;
					end else begin
						parse_radix = RADIX_DEC;
						acc = ADDR_W'(c - CH_ZERO);
						parse_phase = PH_DIGITS;
					end
				end
			end
			PH_ZERO: begin
				parse_phase = PH_DIGITS;
				if ((c == CH_X_LO) || (c == CH_X_UP)) begin
					parse_radix = RADIX_HEX;
				end else begin
					parse_radix = RADIX_OCT;
					take_digit = 1'b1;
				end
			end
			PH_DIGITS: take_digit = 1'b1;
			default: ;
		endcase
		if (take_digit) begin
			if (parse_radix == RADIX_HEX)
				weight = 32'd16;
			else if (parse_radix == RADIX_OCT)
				weight = 32'd8;
			else
				weight = 32'd10;
			if (dec_digit) begin
				acc = acc * weight + ADDR_W'(c - CH_ZERO);
			end else if (parse_radix == RADIX_HEX && c >= CH_A_LO && c <= CH_F_LO) begin
				acc = (acc << 4) | ADDR_W'(c - CH_A_LO + 8'd10);
			end else if (parse_radix == RADIX_HEX && c >= CH_A_UP && c <= CH_F_UP) begin
				acc = (acc << 4) | ADDR_W'(c - CH_A_UP + 8'd10);
			end else if (c == CH_DOT) begin
				if (parts_closed == 2'd3) begin
					done = 1'b1;
				end else begin
					part_store[parts_closed] = acc;
					parts_closed++;
					parse_phase = PH_START;
				end
			end else if (blank) begin
				done = 1'b1;
				case (parts_closed)
					2'd0: begin
						res.ok = 1'b1;
						res.address = acc;
					end
					2'd1: begin
						if (acc <= LIM_TWO_PARTS) begin
							res.ok = 1'b1;
							res.address = acc | (part_store[0] << 24);
						end
					end
					2'd2: begin
						if (acc <= LIM_THREE_PARTS) begin
							res.ok = 1'b1;
							res.address = acc | (part_store[0] << 24) | (part_store[1] << 16);
						end
					end
					default: begin
						if (acc <= LIM_FOUR_PARTS) begin
							res.ok = 1'b1;
							res.address = acc | (part_store[0] << 24) | (part_store[1] << 16)
								| (part_store[2] << 8);
						end
					end
				endcase
			end else begin
				done = 1'b1;
			end
		end
		if (done)
			parse_phase = PH_DONE;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parse_phase = PH_DONE;
			parse_radix = RADIX_DEC;
			acc = '0;
			parts_closed = 2'd0;
			expected_addrs.delete();
			outstanding = 0;
			mismatch_count = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				parse_char(s_axis_tdata[CHAR_W-1:0], s_axis_tuser, produced, predicted);
				if (produced)
					expected_addrs.push_back(predicted);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.ok = m_axis_tdata[0];
				got.address = m_axis_tdata[ADDR_W:1];
				if (expected_addrs.size() == 0) begin
					report_mismatch($sformatf("unexpected result ok=%0b address=%h",
						got.ok, got.address));
				end else begin
					want = expected_addrs.pop_front();
					if (got.ok !== want.ok)
						report_mismatch($sformatf("ok got %0b want %0b", got.ok, want.ok));
					if (got.address !== want.address)
						report_mismatch($sformatf("address got %h want %h",
							got.address, want.address));
				end
			end
			outstanding = expected_addrs.size();
		end
	end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench of the ipv4 dotted-text parser: a short directed run over the
// corner cases, then random address strings in every radix with malformed,
// oversized, overflowing and cut-off strings mixed in, plus raw noise; both
// channels idle at random and the output is held off once for a long stretch
// ----------------------------------------------------------------------------
module tb_top;
	import ipv4p_pkg::*;

	localparam int unsigned CLK_PERIOD = 10;
	localparam int unsigned RESET_CYCLES = 7;
	localparam int unsigned CHAR_TARGET = 1900;
	localparam int unsigned HOLD_AT_CHARS = 700;
	localparam int unsigned PAUSE_AT_CHARS = 1300;
	localparam int unsigned SINK_HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 20;
	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef enum {
		FLAW_NONE,
		FLAW_BAD_END,
		FLAW_FIFTH_PART,
		FLAW_EMPTY_PART,
		FLAW_BAD_START,
		FLAW_OVERSIZE,
		FLAW_CUT,
		FLAW_OVERFLOW
	} flaw_t;

	typedef enum {
		FMT_DEC,
		FMT_OCT,
		FMT_HEX,
		FMT_BARE_HEX
	} part_fmt_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // ch[7:0]
	logic                   s_axis_tuser = 1'b0; // new_string
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;         // ok, address[31:0], zero pad

	int unsigned outstanding;
	int unsigned mismatch_count;
	int unsigned cycle_count = 0;
	int unsigned chars_sent = 0;
	bit          src_idle_on = 1'b1;
	bit          sink_hold_req = 1'b0;
	logic [7:0]  text_q [$];

	ipv4_dotted_text_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	ipv4_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.outstanding    (outstanding),
		.mismatch_count (mismatch_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	function automatic int unsigned pick_gap(input bit active);
		int unsigned r;
		if (!active)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void append_digits(input logic [31:0] v, input int unsigned base);
		logic [7:0] digs [$];
		logic [7:0] d;
		do begin
			d = 8'(v % base);
			v = v / base;
			if (d < 8'd10)
				digs.push_front(CH_ZERO + d);
			else if ($urandom_range(0, 1) != 0)
				digs.push_front(CH_A_LO + d - 8'd10);
			else
				digs.push_front(CH_A_UP + d - 8'd10);
		end while (v != 0);
		foreach (digs[i])
			text_q.push_back(digs[i]);
	endfunction

	function automatic void append_part(input logic [31:0] v, input part_fmt_t fmt);
		int unsigned first;
		case (fmt)
			FMT_DEC: append_digits(v, 10);
			FMT_OCT: begin
				text_q.push_back(CH_ZERO);
				first = text_q.size();
				append_digits(v, 8);
				// octal form still takes 8 and 9
				if ($urandom_range(0, 3) == 0)
					text_q[$urandom_range(first, text_q.size() - 1)] =
						CH_ZERO + 8'($urandom_range(8, 9));
			end
			FMT_HEX: begin
				text_q.push_back(CH_ZERO);
				text_q.push_back(($urandom_range(0, 1) != 0) ? CH_X_LO : CH_X_UP);
				append_digits(v, 16);
			end
			default: begin
				text_q.push_back(CH_ZERO);
				text_q.push_back(($urandom_range(0, 1) != 0) ? CH_X_LO : CH_X_UP);
			end
		endcase
	endfunction

	function automatic void append_long_number();
		int unsigned n;
		n = $urandom_range(10, 14);
		text_q.push_back(CH_ZERO + 8'($urandom_range(1, 9)));
		repeat (n - 1)
			text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function automatic logic [7:0] non_digit();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c >= CH_ZERO && c <= CH_NINE);
		return c;
	endfunction

	function automatic logic [7:0] end_char();
		int unsigned r;
		r = $urandom_range(0, 6);
		if (r == 0)
			return CH_NUL;
		if (r == 1)
			return CH_SPACE;
		return CH_TAB + 8'(r - 2);
	endfunction

	function automatic void build_string();
		flaw_t       flaw;
		part_fmt_t   fmt;
		int unsigned n_parts;
		int unsigned r;
		logic [31:0] lim;
		logic [31:0] v;
		text_q.delete();
		r = $urandom_range(0, 99);
		if (r < 62)
			flaw = FLAW_NONE;
		else if (r < 70)
			flaw = FLAW_BAD_END;
		else if (r < 75)
			flaw = FLAW_FIFTH_PART;
		else if (r < 80)
			flaw = FLAW_EMPTY_PART;
		else if (r < 85)
			flaw = FLAW_BAD_START;
		else if (r < 90)
			flaw = FLAW_OVERSIZE;
		else if (r < 95)
			flaw = FLAW_CUT;
		else
			flaw = FLAW_OVERFLOW;
		n_parts = (flaw == FLAW_FIFTH_PART) ? 5 : $urandom_range(1, 4);
		if (flaw == FLAW_OVERSIZE && n_parts == 1)
			n_parts = 2;
		if (flaw == FLAW_BAD_START)
			text_q.push_back(non_digit());
		for (int p = 0; p < n_parts; p++) begin
			if (p != 0)
				text_q.push_back(CH_DOT);
			if (flaw == FLAW_EMPTY_PART && p == n_parts - 1)
				text_q.push_back(CH_DOT);
			if (p == n_parts - 1) begin
				case (n_parts)
					1: lim = '1;
					2: lim = LIM_TWO_PARTS;
					3: lim = LIM_THREE_PARTS;
					default: lim = LIM_FOUR_PARTS;
				endcase
			end else begin
				lim = ($urandom_range(0, 9) == 0) ? '1 : 32'hff;
			end
			if ($urandom_range(0, 1) != 0)
				v = $urandom & lim;
			else
				v = $urandom_range(0, 255) & lim;
			if (flaw == FLAW_OVERSIZE && p == n_parts - 1)
				v = lim + 32'd1 + ($urandom & lim);
			r = $urandom_range(0, 9);
			if (r < 5)
				fmt = FMT_DEC;
			else if (r < 7)
				fmt = FMT_OCT;
			else if (r < 9)
				fmt = FMT_HEX;
			else
				fmt = FMT_BARE_HEX;
			if (flaw == FLAW_OVERSIZE && fmt == FMT_BARE_HEX)
				fmt = FMT_HEX;
			if (flaw == FLAW_OVERFLOW && $urandom_range(0, 1) != 0)
				append_long_number();
			else
				append_part(v, fmt);
		end
		case (flaw)
			FLAW_BAD_END: text_q.push_back(8'($urandom_range(0, 255)));
			FLAW_CUT: ;
			default: text_q.push_back(end_char());
		endcase
	endfunction

	task automatic send_char(input logic [7:0] c, input logic first);
		int unsigned gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tuser <= first;
		do
			@(posedge clk);
		while (!s_axis_tready);
		gap = pick_gap(src_idle_on);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_text_q();
		foreach (text_q[i])
			send_char(text_q[i], i == 0);
		chars_sent += text_q.size();
	endtask

	task automatic send_text(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
		send_text_q();
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		int unsigned mode_left;
		bit          sink_idle_on;
		hold_left = 0;
		stall_left = 0;
		mode_left = 0;
		sink_idle_on = 1'b1;
		forever begin
			@(posedge clk);
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				hold_left = SINK_HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode_left = $urandom_range(64, 256);
				sink_idle_on = ($urandom_range(0, 3) != 0);
			end else begin
				mode_left--;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left = pick_gap(sink_idle_on);
			end
		end
	end

	initial begin
		bit hold_issued;
		bit pause_done;
		hold_issued = 1'b0;
		pause_done = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// character before any string start is ignored
		send_char(CH_X_LO, 1'b0);
		// empty string
		send_char(CH_NUL, 1'b1);
		// bare hex prefix ended by vertical tab
		send_text("0x");
		send_char(CH_TAB + 8'd2, 1'b0);
		// fifth part
		send_text("9.8.7.6.");
		// oversized last of four parts
		send_text("0.0.0.256");
		send_char(CH_SPACE, 1'b0);
		// octal with digit 8, then a bad terminator at the top byte value
		send_text("08");
		send_char(8'hff, 1'b0);
		// first part wraps out of the top byte
		send_text("256.1");
		send_char(CH_NUL, 1'b0);
		wait_drained();

		while (chars_sent < CHAR_TARGET) begin
			src_idle_on = ($urandom_range(0, 3) != 0);
			if (!hold_issued && chars_sent >= HOLD_AT_CHARS) begin
				hold_issued = 1'b1;
				sink_hold_req = 1'b1;
				src_idle_on = 1'b0;
			end
			if (!pause_done && chars_sent >= PAUSE_AT_CHARS) begin
				pause_done = 1'b1;
				wait_drained();
			end
			if ($urandom_range(0, 99) < 6) begin
				repeat ($urandom_range(1, 6))
					send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else begin
				build_string();
				send_text_q();
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 3))
						send_char(8'($urandom_range(0, 255)), 1'b0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

// File: ipv4_dotted_text_parser.f
sv/ipv4p_pkg.sv
sv/ipv4p_core.sv
sv/ipv4_dotted_text_parser.sv
verif/ipv4_result_checker.sv
verif/tb_top.sv
